// ----- hw/rtl/mdq_pkg.sv -----
// Shared constants and controller/datapath interface types for the mouse quadrature unit.
`default_nettype none

package mdq_pkg;

  // Field widths fixed by the interface.
  localparam int DELTA_W = 16;
  localparam int DELAY_W = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register widths.
  localparam int BASE_W  = 16;
  localparam int SHIFT_W = 3;
  localparam int THR_W   = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_THR   = 2'd2;

  // Register reset values.
  localparam logic [BASE_W-1:0]  BASE_PERIOD_RST = 16'd12000;
  localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RST = 3'd3;
  localparam logic [THR_W-1:0]   SMALL_THR_RST   = 4'd2;

  // Default step limit per axis.
  localparam int MAX_STEP_COUNT_DEF = 15;

  // Percent accumulator: increment never exceeds PCT, the sum stays below 2*PCT.
  localparam int PCT   = 100;
  localparam int PCT_W = 7;
  localparam int ACC_W = 8;

  // Pins raised first.
  localparam logic [1:0] PIN_UP    = 2'd0;
  localparam logic [1:0] PIN_DOWN  = 2'd1;
  localparam logic [1:0] PIN_LEFT  = 2'd2;
  localparam logic [1:0] PIN_RIGHT = 2'd3;

  // Divider operand selection.
  localparam logic DIV_SEL_DELAY = 1'b0;
  localparam logic DIV_SEL_INC   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic lat_delay;
    logic lat_inc;
    logic emit_major;
    logic emit_minor;
  } mdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
    logic div_done;
    logic minor_due;
    logic last_step;
    logic steps_zero;
  } mdq_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mouse_delta_to_quadrature_steps_unit.sv -----
// Top level of the mouse delta to quadrature move unit.
//
// An item (delta_x, delta_y) is taken at a rising edge with start high and
// busy low. The block turns it into a run of quadrature moves, each shown on
// axis, negative, lead_pin, phase_delay_us and last for exactly one cycle
// with strobe high; last marks the final move of the item. A zero delta pair
// gives no result and frees the block by going from the check state to idle.
// Sequence: a check of the counts, then two passes through the shared
// bit-serial divider (phase delay, then percent increment), then one move per
// cycle. An item gives at most 2*MAX_STEP_COUNT moves. Busy falls as the last
// result goes out, so the next item may follow at once. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it only
// while busy is low, as the block itself does not enforce this. An unused
// index is ignored. Reset (rst, synchronous) returns the controller to idle,
// clears strobe and loads the register reset values. Results cannot be held
// off by the receiver.
`default_nettype none

module mouse_delta_to_quadrature_steps_unit #(
  parameter int MAX_STEP_COUNT = mdq_pkg::MAX_STEP_COUNT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [mdq_pkg::DELTA_W-1:0]   delta_x,
  input  wire logic signed [mdq_pkg::DELTA_W-1:0]   delta_y,
  input  wire logic                                 cfg_we,
  input  wire logic [mdq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mdq_pkg::CFG_W-1:0]            cfg_data,
  output logic                                      strobe,
  output logic                                      axis,
  output logic                                      negative,
  output logic [1:0]                                lead_pin,
  output logic [mdq_pkg::DELAY_W-1:0]               phase_delay_us,
  output logic                                      last
);

  mdq_pkg::mdq_cmd_t    cmd;
  mdq_pkg::mdq_status_t status;

  mdq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mdq_datapath #(
    .MAX_STEP_COUNT (MAX_STEP_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .delta_x        (delta_x),
    .delta_y        (delta_y),
    .strobe         (strobe),
    .axis           (axis),
    .negative       (negative),
    .lead_pin       (lead_pin),
    .phase_delay_us (phase_delay_us),
    .last           (last)
  );

  // A result only follows a cycle in which the block was at work.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // Taking an item always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item taken but block not busy afterwards");

  // All moves of one item carry the same phase delay.
  assert property (@(posedge clk) disable iff (rst)
                   (strobe && $past(strobe) && !$past(last)) |-> $stable(phase_delay_us))
    else $error("phase delay changed within one item");

endmodule

`default_nettype wire

// ----- hw/rtl/mdq_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mdq_divider #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= CNT_W'(DVD_W);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (running) begin
      if (fits) begin
        rem <= DVS_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DVS_W-1:0];
      end
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- hw/rtl/mdq_datapath.sv -----
// Datapath: registers, step counts, shared divider, accumulator and result registers.
`default_nettype none

module mdq_datapath #(
  parameter int MAX_STEP_COUNT = mdq_pkg::MAX_STEP_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mdq_pkg::mdq_cmd_t               cmd,
  output mdq_pkg::mdq_status_t                 status,
  input  wire logic                            cfg_we,
  input  wire logic [mdq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mdq_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic signed [mdq_pkg::DELTA_W-1:0] delta_x,
  input  wire logic signed [mdq_pkg::DELTA_W-1:0] delta_y,
  output logic                                 strobe,
  output logic                                 axis,
  output logic                                 negative,
  output logic [1:0]                           lead_pin,
  output logic [mdq_pkg::DELAY_W-1:0]          phase_delay_us,
  output logic                                 last
);

  localparam int CW    = $clog2(MAX_STEP_COUNT + 1);
  localparam int SW    = CW + 1;
  localparam int DW    = mdq_pkg::DELTA_W;
  localparam int DVD_W = mdq_pkg::BASE_W;

  logic [mdq_pkg::BASE_W-1:0]  base_period;
  logic [mdq_pkg::SHIFT_W-1:0] scale_shift;
  logic [mdq_pkg::THR_W-1:0]   small_thr;

  logic [DW-1:0] mag_x, mag_y;
  logic [CW-1:0] cnt_x_in, cnt_y_in;
  logic [CW-1:0] cx, cy;
  logic          nx, ny;

  logic          maj_ax, maj_neg, min_ax, min_neg;
  logic [CW-1:0] major, minor;

  logic [DVD_W-1:0] div_dividend;
  logic [SW-1:0]    div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  logic [mdq_pkg::DELAY_W-1:0] delay;
  logic [mdq_pkg::PCT_W-1:0]   inc;
  logic [mdq_pkg::ACC_W-1:0]   acc;
  logic [mdq_pkg::ACC_W-1:0]   acc_sum;
  logic [CW-1:0]               steps;
  logic                        minor_due;

  // Step count of one axis: scale large magnitudes, keep small ones, clamp to the limit.
  function automatic logic [CW-1:0] axis_count(input logic [DW-1:0] mag,
                                               input logic [mdq_pkg::SHIFT_W-1:0] sh,
                                               input logic [mdq_pkg::THR_W-1:0] thr);
    logic [DW-1:0] c;
    begin
      c = mag;
      if (mag > DW'(thr)) begin
        c = mag >> sh;
        if (c == '0) begin
          c = DW'(1);
        end
      end
      if (c > DW'(MAX_STEP_COUNT)) begin
        c = DW'(MAX_STEP_COUNT);
      end
      axis_count = c[CW-1:0];
    end
  endfunction

  // Pin raised first for a move on one axis.
  function automatic logic [1:0] lead_of(input logic ax, input logic neg);
    begin
      if (ax) begin
        lead_of = neg ? mdq_pkg::PIN_LEFT : mdq_pkg::PIN_RIGHT;
      end else begin
        lead_of = neg ? mdq_pkg::PIN_UP : mdq_pkg::PIN_DOWN;
      end
    end
  endfunction

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_period <= mdq_pkg::BASE_PERIOD_RST;
      scale_shift <= mdq_pkg::SCALE_SHIFT_RST;
      small_thr   <= mdq_pkg::SMALL_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdq_pkg::REG_BASE_PERIOD: base_period <= cfg_data[mdq_pkg::BASE_W-1:0];
        mdq_pkg::REG_SCALE_SHIFT: scale_shift <= cfg_data[mdq_pkg::SHIFT_W-1:0];
        mdq_pkg::REG_SMALL_THR:   small_thr   <= cfg_data[mdq_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitudes of the incoming item; the most negative value gives 0x8000.
  always_comb begin
    mag_x    = delta_x[DW-1] ? DW'(-delta_x) : DW'(delta_x);
    mag_y    = delta_y[DW-1] ? DW'(-delta_y) : DW'(delta_y);
    cnt_x_in = (mag_x == '0) ? '0 : axis_count(mag_x, scale_shift, small_thr);
    cnt_y_in = (mag_y == '0) ? '0 : axis_count(mag_y, scale_shift, small_thr);
  end

  // Capture the counts and signs when an item is taken.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= cnt_x_in;
      cy <= cnt_y_in;
      nx <= delta_x[DW-1];
      ny <= delta_y[DW-1];
    end
  end

  // The larger count drives the loop; y drives on a tie.
  always_comb begin
    if (cx > cy) begin
      major   = cx;
      minor   = cy;
      maj_ax  = 1'b0;
      maj_neg = nx;
      min_ax  = 1'b1;
      min_neg = ny;
    end else begin
      major   = cy;
      minor   = cx;
      maj_ax  = 1'b1;
      maj_neg = ny;
      min_ax  = 1'b0;
      min_neg = nx;
    end
  end

  // Divider operands: base period over the count sum, or minor percent over major.
  always_comb begin
    if (cmd.div_sel == mdq_pkg::DIV_SEL_INC) begin
      div_dividend = DVD_W'(DVD_W'(minor) * DVD_W'(mdq_pkg::PCT));
      div_divisor  = SW'(major);
    end else begin
      div_dividend = base_period;
      div_divisor  = SW'(cx) + SW'(cy);
    end
  end

  mdq_divider #(
    .DVD_W (DVD_W),
    .DVS_W (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Accumulator step for the current major move.
  always_comb begin
    acc_sum   = acc + mdq_pkg::ACC_W'(inc);
    minor_due = (acc_sum >= mdq_pkg::ACC_W'(mdq_pkg::PCT));
  end

  // Delay, increment, accumulator and remaining step count.
  always_ff @(posedge clk) begin
    if (cmd.lat_delay) begin
      delay <= mdq_pkg::DELAY_W'(div_quo) + mdq_pkg::DELAY_W'(1);
    end
    if (cmd.lat_inc) begin
      inc   <= div_quo[mdq_pkg::PCT_W-1:0];
      acc   <= '0;
      steps <= major;
    end else if (cmd.emit_major) begin
      acc   <= minor_due ? mdq_pkg::ACC_W'(acc_sum - mdq_pkg::ACC_W'(mdq_pkg::PCT)) : acc_sum;
      steps <= steps - 1'b1;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_major | cmd.emit_minor;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.emit_major) begin
      axis           <= maj_ax;
      negative       <= maj_neg;
      lead_pin       <= lead_of(maj_ax, maj_neg);
      phase_delay_us <= delay;
      last           <= (steps == CW'(1)) && !minor_due;
    end else if (cmd.emit_minor) begin
      axis           <= min_ax;
      negative       <= min_neg;
      lead_pin       <= lead_of(min_ax, min_neg);
      phase_delay_us <= delay;
      last           <= (steps == '0);
    end
  end

  // Status towards the controller.
  always_comb begin
    status.zero       = (cx == '0) && (cy == '0);
    status.div_done   = div_done;
    status.minor_due  = minor_due;
    status.last_step  = (steps == CW'(1));
    status.steps_zero = (steps == '0);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mdq_ctrl.sv -----
// Controller state machine that sequences the divisions and the emitted moves.
`default_nettype none

module mdq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire mdq_pkg::mdq_status_t status,
  output mdq_pkg::mdq_cmd_t         cmd,
  output logic                      busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DLY   = 3'd2;
  localparam logic [2:0] S_INC   = 3'd3;
  localparam logic [2:0] S_MAJOR = 3'd4;
  localparam logic [2:0] S_MINOR = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mdq_pkg::DIV_SEL_DELAY;
          state_next    = S_DLY;
        end
      end
      S_DLY: begin
        if (status.div_done) begin
          cmd.lat_delay = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = mdq_pkg::DIV_SEL_INC;
          state_next    = S_INC;
        end
      end
      S_INC: begin
        cmd.div_sel = mdq_pkg::DIV_SEL_INC;
        if (status.div_done) begin
          cmd.lat_inc = 1'b1;
          state_next  = S_MAJOR;
        end
      end
      S_MAJOR: begin
        cmd.emit_major = 1'b1;
        if (status.minor_due) begin
          state_next = S_MINOR;
        end else if (status.last_step) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_MAJOR;
        end
      end
      S_MINOR: begin
        cmd.emit_minor = 1'b1;
        state_next     = status.steps_zero ? S_IDLE : S_MAJOR;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire
